[rtl/core/dq_pkg.sv]
`timescale 1ns / 1ps
package dq_pkg;

   // default number of words held
   localparam int DQ_DEPTH = 1024;

   localparam int DQ_WORD_W = 32;
   localparam int DQ_OP_W   = 3;

   typedef logic [DQ_OP_W-1:0] dq_op_type;

   // operation codes; the unused codes act as no operation
   localparam dq_op_type DQ_OP_NONE       = 3'd0;
   localparam dq_op_type DQ_OP_PUSH_FRONT = 3'd1;
   localparam dq_op_type DQ_OP_PUSH_BACK  = 3'd2;
   localparam dq_op_type DQ_OP_POP_FRONT  = 3'd3;
   localparam dq_op_type DQ_OP_POP_BACK   = 3'd4;

endpackage

[rtl/core/double_ended_queue.sv]
`timescale 1ns / 1ps
// double-ended queue of signed 32-bit words in a circular store of DEPTH
// entries, pushed and popped at either end
// request channel (req_valid / req_stall): one transaction carries an
// operation (none, push front, push back, pop front, pop back) and a push
// value. every request transaction gives exactly one response transaction.
// response channel (rsp_valid / rsp_stall): the popped word with pop_ok, the
// push_dropped flag for a push into a full queue, and the front word, back
// word, entry count and empty / full flags as they stand after the operation
//
// timing: when a request is taken, the pointers are updated, the store is
// written and both store reads are issued; the response is loaded into the
// output register in the load state that follows, once the response register
// is free. the block takes no new request until that response is loaded, as
// the registered read of the word store has to return the new front and back
// words before the next operation may pop them
//
// reset clears the pointers and the count: the queue comes up empty. the word
// store is not cleared. a stalled response holds its value; one more request
// may be taken meanwhile and waits in the block until the response register
// is free
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH = DQ_DEPTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [DQ_OP_W-1:0]          req_operation,
   input  logic signed [DQ_WORD_W-1:0] req_push_value,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DQ_WORD_W-1:0] rsp_popped_value,
   output logic                        rsp_pop_ok,
   output logic                        rsp_push_dropped,
   output logic signed [DQ_WORD_W-1:0] rsp_front_value,
   output logic signed [DQ_WORD_W-1:0] rsp_back_value,
   output logic [CW-1:0]               rsp_entry_count,
   output logic                        rsp_is_empty,
   output logic                        rsp_is_full
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOAD = 1'b1;

   localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   typedef logic [DQ_WORD_W-1:0] word_type;

   // word store, one write and two reads per cycle, registered read data
   word_type word_store [DEPTH];

   logic          state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;

   // current front and back words, kept for pops
   word_type front_ff, front_in;
   word_type back_ff, back_in;

   // store access of the request being taken
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_front_addr;
   logic [AW-1:0] rd_back_addr;
   word_type      rd_front_ff;
   word_type      rd_back_ff;

   // results held between the request cycle and the load cycle
   word_type pend_popped_ff, pend_popped_in;
   logic     pend_pop_ok_ff, pend_pop_ok_in;
   logic     pend_dropped_ff, pend_dropped_in;
   word_type pend_wdata_ff;
   logic     hit_front_ff, hit_front_in;
   logic     hit_back_ff, hit_back_in;

   // response register
   logic     rsp_valid_ff;
   word_type rsp_popped_ff;
   logic     rsp_pop_ok_ff;
   logic     rsp_dropped_ff;
   word_type rsp_front_ff;
   word_type rsp_back_ff;
   logic [CW-1:0] rsp_count_ff;

   logic req_take;
   logic out_free;
   logic load_now;
   logic is_full_now;
   logic is_empty_now;
   logic after_empty;
   word_type front_word;
   word_type back_word;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == PTR_LAST) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      return (p == '0) ? PTR_LAST : p - AW'(1);
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // the response register may be loaded when empty or being emptied
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_now = (state_ff == ST_LOAD) && out_free;

   assign is_full_now  = (count_ff == CNT_FULL);
   assign is_empty_now = (count_ff == '0);

   // operation decode, pointer and count update
   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      wr_en           = 1'b0;
      wr_addr         = tail_ff;
      pend_popped_in  = '0;
      pend_pop_ok_in  = 1'b0;
      pend_dropped_in = 1'b0;
      unique case (req_operation)
         DQ_OP_PUSH_FRONT: begin
            if (is_full_now) begin
               pend_dropped_in = 1'b1;
            end else begin
               head_in  = ptr_dec(head_ff);
               wr_en    = 1'b1;
               wr_addr  = ptr_dec(head_ff);
               count_in = count_ff + CW'(1);
            end
         end
         DQ_OP_PUSH_BACK: begin
            if (is_full_now) begin
               pend_dropped_in = 1'b1;
            end else begin
               tail_in  = ptr_inc(tail_ff);
               wr_en    = 1'b1;
               wr_addr  = tail_ff;
               count_in = count_ff + CW'(1);
            end
         end
         DQ_OP_POP_FRONT: begin
            if (!is_empty_now) begin
               pend_pop_ok_in = 1'b1;
               pend_popped_in = front_ff;
               head_in        = ptr_inc(head_ff);
               count_in       = count_ff - CW'(1);
            end
         end
         DQ_OP_POP_BACK: begin
            if (!is_empty_now) begin
               pend_pop_ok_in = 1'b1;
               pend_popped_in = back_ff;
               tail_in        = ptr_dec(tail_ff);
               count_in       = count_ff - CW'(1);
            end
         end
         default: begin
            // no operation, peek only
         end
      endcase
      rd_front_addr = head_in;
      rd_back_addr  = ptr_dec(tail_in);
      // the store read returns the old word where this cycle writes
      hit_front_in  = wr_en && (wr_addr == rd_front_addr);
      hit_back_in   = wr_en && (wr_addr == rd_back_addr);
   end

   // store: write of a push, read of the new front and back entries
   always_ff @(posedge clock) begin
      if (req_take && wr_en) begin
         word_store[wr_addr] <= req_push_value;
      end
      if (req_take) begin
         rd_front_ff <= word_store[rd_front_addr];
         rd_back_ff  <= word_store[rd_back_addr];
      end
   end

   // front and back after the operation, with the pushed word forwarded
   assign after_empty = (count_ff == '0);
   always_comb begin
      front_word = hit_front_ff ? pend_wdata_ff : rd_front_ff;
      back_word  = hit_back_ff ? pend_wdata_ff : rd_back_ff;
      front_in   = after_empty ? '0 : front_word;
      back_in    = after_empty ? '0 : back_word;
   end

   always_comb begin
      priority if (req_take) begin
         state_in = ST_LOAD;
      end else if (load_now) begin
         state_in = ST_IDLE;
      end else begin
         state_in = state_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_take) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
         if (load_now) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         pend_popped_ff  <= pend_popped_in;
         pend_pop_ok_ff  <= pend_pop_ok_in;
         pend_dropped_ff <= pend_dropped_in;
         pend_wdata_ff   <= req_push_value;
         hit_front_ff    <= hit_front_in;
         hit_back_ff     <= hit_back_in;
      end
      if (load_now) begin
         front_ff       <= front_in;
         back_ff        <= back_in;
         rsp_popped_ff  <= pend_popped_ff;
         rsp_pop_ok_ff  <= pend_pop_ok_ff;
         rsp_dropped_ff <= pend_dropped_ff;
         rsp_front_ff   <= front_in;
         rsp_back_ff    <= back_in;
         rsp_count_ff   <= count_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_pop_ok       = rsp_pop_ok_ff;
   assign rsp_push_dropped = rsp_dropped_ff;
   assign rsp_front_value  = rsp_front_ff;
   assign rsp_back_value   = rsp_back_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_is_empty     = (rsp_count_ff == '0);
   assign rsp_is_full      = (rsp_count_ff == CNT_FULL);

endmodule
